/* design/pcf_pkg.sv */
// pcf_pkg: shared types and constants for the pty channel fifo block
// used by pcf_front, pcf_back and pty_channel_fifo_onlcr; no dependencies

package pcf_pkg;

	localparam int RING_DEPTH_DEF = 1024;
	localparam int MAX_REFS_DEF   = 255;
	localparam int REF_W          = 8;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_NL = 8'h0A;

	typedef enum logic [2:0] {
		ACT_OPEN_MASTER  = 3'd0,
		ACT_SET_LOCK     = 3'd1,
		ACT_OPEN_SLAVE   = 3'd2,
		ACT_CLOSE_SLAVE  = 3'd3,
		ACT_CLOSE_MASTER = 3'd4,
		ACT_SLAVE_WRITE  = 3'd5,
		ACT_MASTER_READ  = 3'd6,
		ACT_UNUSED       = 3'd7
	} pcf_action_t;

	typedef enum logic [3:0] {
		ST_OK     = 4'd0,
		ST_BADF   = 4'd1,
		ST_PIPE   = 4'd2,
		ST_FULL   = 4'd3,
		ST_EOF    = 4'd4,
		ST_AGAIN  = 4'd5,
		ST_NOENT  = 4'd6,
		ST_ACCES  = 4'd7,
		ST_IO     = 4'd8,
		ST_NOSLOT = 4'd9
	} pcf_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CRLF,
		BK_RDWAIT
	} pcf_bk_state_t;

	// register indexes on the config port
	typedef enum logic [0:0] {
		REG_OPOST = 1'b0,
		REG_ONLCR = 1'b1
	} pcf_reg_t;

	typedef struct packed {
		pcf_action_t action;
		logic [7:0]  write_data;
		logic        lock_value;
		logic        last_of_call;
		logic        crlf;
	} pcf_item_t;

endpackage

/* design/pty_channel_fifo_onlcr.sv */
// pty_channel_fifo_onlcr: top level of one pty pair with slave-to-master byte ring
// depends on pcf_pkg, pcf_front, pcf_back, pcf_ram

// One word is accepted per action and one result word is returned for it, in
// order. A word enters a two-entry queue, from which the executing stage takes
// it in order; most actions finish there in the idle state. A slave write of a
// newline with translation on goes on to state BK_CRLF, as the cr and the
// newline are written one after the other on the ring's single write port, and
// a master read that pops a byte goes on to state BK_RDWAIT, waiting on the
// ring's registered read. The ring is not cleared after reset: its head, tail
// and fill count start at zero and a read only reaches bytes written before.
// Registers: 0x0 output processing enable, 0x4 newline-to-crlf enable, both
// reset to 1.

module pty_channel_fifo_onlcr #(
	parameter int RING_DEPTH = pcf_pkg::RING_DEPTH_DEF,
	parameter int MAX_REFS   = pcf_pkg::MAX_REFS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [7:0]  write_data,
	input  logic        lock_value,
	input  logic        last_of_call,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  status,
	output logic [7:0]  read_data,
	output logic        hangup_request,
	output logic        released,
	output logic        last_of_call_out
);

	logic               opost_q;
	logic               onlcr_q;
	logic               cfg_wr;
	pcf_pkg::pcf_reg_t  reg_sel;
	logic               hd_valid;
	pcf_pkg::pcf_item_t hd_item;
	logic               hd_pop;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = pcf_pkg::pcf_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opost_q <= 1'b1;
			onlcr_q <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_sel)
				pcf_pkg::REG_OPOST: opost_q <= pwdata[0];
				pcf_pkg::REG_ONLCR: onlcr_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			pcf_pkg::REG_OPOST: prdata = {31'd0, opost_q};
			pcf_pkg::REG_ONLCR: prdata = {31'd0, onlcr_q};
			default:            prdata = 32'd0;
		endcase
	end

	pcf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.write_data   (write_data),
		.lock_value   (lock_value),
		.last_of_call (last_of_call),
		.opost        (opost_q),
		.onlcr        (onlcr_q),
		.hd_valid     (hd_valid),
		.hd_item      (hd_item),
		.hd_pop       (hd_pop)
	);

	pcf_back #(
		.RING_DEPTH (RING_DEPTH),
		.MAX_REFS   (MAX_REFS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.hd_valid         (hd_valid),
		.hd_item          (hd_item),
		.hd_pop           (hd_pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.read_data        (read_data),
		.hangup_request   (hangup_request),
		.released         (released),
		.last_of_call_out (last_of_call_out)
	);

endmodule

/* design/pcf_ram.sv */
// pcf_ram: generic single write port, single read port ram with registered read
// no dependencies

module pcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/pcf_front.sv */
// pcf_front: accepts words, classifies newline translation, holds a two entry queue
// depends on pcf_pkg

module pcf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        action,
	input  logic [7:0]        write_data,
	input  logic              lock_value,
	input  logic              last_of_call,
	input  logic              opost,
	input  logic              onlcr,
	output logic              hd_valid,
	output pcf_pkg::pcf_item_t hd_item,
	input  logic              hd_pop
);

	pcf_pkg::pcf_item_t entry_q [2];
	pcf_pkg::pcf_item_t new_item;
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign hd_valid = (cnt_q != 2'd0);
	assign hd_item  = entry_q[rd_ptr_q];

	always_comb begin
		new_item.action       = pcf_pkg::pcf_action_t'(action);
		new_item.write_data   = write_data;
		new_item.lock_value   = lock_value;
		new_item.last_of_call = last_of_call;
		// the user must keep config static while words are in flight; not enforced here
		new_item.crlf         = opost && onlcr && (write_data == pcf_pkg::CH_NL);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (hd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !hd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && hd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* design/pcf_back.sv */
// pcf_back: executes queued words against the pair state and the byte ring
// depends on pcf_pkg and pcf_ram

module pcf_back #(
	parameter int RING_DEPTH = pcf_pkg::RING_DEPTH_DEF,
	parameter int MAX_REFS   = pcf_pkg::MAX_REFS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hd_valid,
	input  pcf_pkg::pcf_item_t hd_item,
	output logic               hd_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [3:0]         status,
	output logic [7:0]         read_data,
	output logic               hangup_request,
	output logic               released,
	output logic               last_of_call_out
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int FW = AW + 1;
	localparam int RW = pcf_pkg::REF_W;

	pcf_pkg::pcf_bk_state_t state_q, state_d;
	logic          alloc_q, alloc_d;
	logic          lock_q, lock_d;
	logic [RW-1:0] mcount_q, mcount_d;
	logic [RW-1:0] scount_q, scount_d;
	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [FW-1:0] fill_q, fill_d;

	logic          out_valid_q;
	logic [3:0]    status_q;
	logic [7:0]    rdata_q;
	logic          hup_q;
	logic          rel_q;
	logic          last_q;

	logic          slot_free;
	logic          done;
	logic          ring_full;
	logic          ram_we;
	logic [7:0]    ram_wdata;
	logic [7:0]    ram_rdata;
	pcf_pkg::pcf_status_t res_status;
	logic [7:0]    res_rdata;
	logic          res_hup;
	logic          res_rel;
	logic [RW-1:0] cnt_dec;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	pcf_ram #(
		.WIDTH (8),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata (ram_wdata),
		.raddr (tail_q),
		.rdata (ram_rdata)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign ring_full = (fill_q == FW'(RING_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pcf_pkg::BK_IDLE;
			alloc_q  <= 1'b0;
			lock_q   <= 1'b0;
			mcount_q <= '0;
			scount_q <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
		end else begin
			state_q  <= state_d;
			alloc_q  <= alloc_d;
			lock_q   <= lock_d;
			mcount_q <= mcount_d;
			scount_q <= scount_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			fill_q   <= fill_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		alloc_d    = alloc_q;
		lock_d     = lock_q;
		mcount_d   = mcount_q;
		scount_d   = scount_q;
		head_d     = head_q;
		tail_d     = tail_q;
		fill_d     = fill_q;
		ram_we     = 1'b0;
		ram_wdata  = hd_item.write_data;
		done       = 1'b0;
		res_status = pcf_pkg::ST_OK;
		res_rdata  = 8'd0;
		res_hup    = 1'b0;
		res_rel    = 1'b0;
		cnt_dec    = '0;
		case (state_q)
			pcf_pkg::BK_IDLE: begin
				if (hd_valid && slot_free) begin
					done = 1'b1;
					if (hd_item.action == pcf_pkg::ACT_UNUSED) begin
						res_status = pcf_pkg::ST_IO;
					end else if (hd_item.action == pcf_pkg::ACT_OPEN_MASTER) begin
						if (alloc_q) begin
							res_status = pcf_pkg::ST_NOSLOT;
						end else begin
							alloc_d  = 1'b1;
							lock_d   = 1'b1;
							mcount_d = RW'(1);
							scount_d = '0;
							head_d   = '0;
							tail_d   = '0;
							fill_d   = '0;
						end
					end else if (!alloc_q) begin
						res_status = (hd_item.action == pcf_pkg::ACT_OPEN_SLAVE) ?
							pcf_pkg::ST_NOENT : pcf_pkg::ST_BADF;
					end else begin
						case (hd_item.action)
							pcf_pkg::ACT_SET_LOCK: begin
								lock_d = hd_item.lock_value;
							end
							pcf_pkg::ACT_OPEN_SLAVE: begin
								if (lock_q) begin
									res_status = pcf_pkg::ST_ACCES;
								end else if (mcount_q == '0) begin
									res_status = pcf_pkg::ST_IO;
								end else if (scount_q < RW'(MAX_REFS)) begin
									scount_d = scount_q + 1'b1;
								end
							end
							pcf_pkg::ACT_CLOSE_SLAVE: begin
								cnt_dec  = (scount_q != '0) ? scount_q - 1'b1 : '0;
								scount_d = cnt_dec;
								if (mcount_q == '0 && cnt_dec == '0) begin
									alloc_d = 1'b0;
									res_rel = 1'b1;
								end
							end
							pcf_pkg::ACT_CLOSE_MASTER: begin
								cnt_dec  = (mcount_q != '0) ? mcount_q - 1'b1 : '0;
								mcount_d = cnt_dec;
								if (cnt_dec == '0) begin
									res_hup = 1'b1;
									if (scount_q == '0) begin
										alloc_d = 1'b0;
										res_rel = 1'b1;
									end
								end
							end
							pcf_pkg::ACT_SLAVE_WRITE: begin
								if (mcount_q == '0) begin
									res_status = pcf_pkg::ST_PIPE;
								end else if (ring_full) begin
									res_status = pcf_pkg::ST_FULL;
								end else begin
									ram_we    = 1'b1;
									ram_wdata = hd_item.crlf ? pcf_pkg::CH_CR :
										hd_item.write_data;
									head_d    = ring_next(head_q);
									fill_d    = fill_q + 1'b1;
									if (hd_item.crlf) begin
										// newline goes in on the next cycle
										done    = 1'b0;
										state_d = pcf_pkg::BK_CRLF;
									end
								end
							end
							pcf_pkg::ACT_MASTER_READ: begin
								if (fill_q == '0) begin
									res_status = (scount_q == '0) ? pcf_pkg::ST_EOF :
										pcf_pkg::ST_AGAIN;
								end else begin
									tail_d  = ring_next(tail_q);
									fill_d  = fill_q - 1'b1;
									done    = 1'b0;
									state_d = pcf_pkg::BK_RDWAIT;
								end
							end
							default: begin
								res_status = pcf_pkg::ST_IO;
							end
						endcase
					end
				end
			end
			pcf_pkg::BK_CRLF: begin
				done    = 1'b1;
				state_d = pcf_pkg::BK_IDLE;
				if (ring_full) begin
					// the cr already pushed stays in the ring
					res_status = pcf_pkg::ST_FULL;
				end else begin
					ram_we = 1'b1;
					head_d = ring_next(head_q);
					fill_d = fill_q + 1'b1;
				end
			end
			pcf_pkg::BK_RDWAIT: begin
				done      = 1'b1;
				state_d   = pcf_pkg::BK_IDLE;
				res_rdata = ram_rdata;
			end
			default: begin
				state_d = pcf_pkg::BK_IDLE;
			end
		endcase
	end

	assign hd_pop = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			status_q <= res_status;
			rdata_q  <= res_rdata;
			hup_q    <= res_hup;
			rel_q    <= res_rel;
			last_q   <= hd_item.last_of_call;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign read_data        = rdata_q;
	assign hangup_request   = hup_q;
	assign released         = rel_q;
	assign last_of_call_out = last_q;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(RING_DEPTH))
		else $error("ring fill above depth");

	a_slot_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcf_pkg::BK_CRLF || state_q == pcf_pkg::BK_RDWAIT) |-> !out_valid_q)
		else $error("result slot busy during a two cycle word");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		hd_pop |-> hd_valid)
		else $error("pop from empty queue");

	a_release_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res_rel) |=> !alloc_q)
		else $error("released but pair still allocated");

	a_slave_sat: assert property (@(posedge clk) disable iff (!arst_n)
		scount_q <= RW'(MAX_REFS))
		else $error("slave count above limit");
`endif

endmodule
